/* src/assert_macros.svh */
// assertion macros used by the neuron core
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* src/lif_pkg.sv */
// types and constants of the leaky integrate-and-fire neuron core
// no dependencies
`timescale 1ns / 1ps

package lif_pkg;

  localparam int DATA_W    = 32;
  localparam int WIDE_W    = 64;
  localparam int ADDR_W    = 4;
  localparam int DIV_STEPS = 64;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  // limit on the magnitude of one euler step
  localparam logic [WIDE_W-1:0] DELTA_CAP = 64'h0000_0002_0000_0000;

  localparam logic [DATA_W-1:0] TC_RESET  = 32'h0001_0000;
  localparam logic [DATA_W-1:0] RES_RESET = 32'h0001_0000;
  localparam logic [DATA_W-1:0] VR_RESET  = 32'h0000_0000;

  typedef enum logic [1:0] {
    REG_TIME_CONSTANT     = 2'd0,
    REG_RESISTANCE        = 2'd1,
    REG_RESTING_POTENTIAL = 2'd2
  } reg_idx_t;

  typedef enum logic {
    OP_PULSE = 1'b0,
    OP_TICK  = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_COMB,
    S_DIV,
    S_FIN,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [DATA_W-1:0]        time_constant;
    logic [DATA_W-1:0]        resistance;
    logic signed [DATA_W-1:0] resting_potential;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* src/leaky_integrate_fire_neuron_core.sv */
// leaky integrate-and-fire neuron: sequencer, accumulator, potential and output stage
// depends on lif_pkg, lif_regs, lif_div and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

// A pulse transaction adds its signed Q16.16 weight to the input accumulator with
// saturation and returns nothing. A tick transaction runs one Euler step and returns
// one result (spike flag and new potential). A tick passes from acceptance to result
// through a multiply state, a combine state that starts the bit-serial restoring
// divider (64 quotient steps, then a done flag), a state that updates and saturates
// the potential, and a state that compares it against threshold and waits for the
// output register to be free. The input side is not ready while a tick is in progress;
// a pulse can be accepted while a previous result still waits on the output register.
// Registers sit at byte addresses 0x0 (time_constant), 0x4 (resistance) and 0x8
// (resting_potential); pready is always high.
module leaky_integrate_fire_neuron_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lif_pkg::ADDR_W-1:0]        paddr,
  input  logic [lif_pkg::DATA_W-1:0]        pwdata,
  output logic [lif_pkg::DATA_W-1:0]        prdata,
  output logic                              pready,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_opcode,
  input  logic signed [lif_pkg::DATA_W-1:0] in_pulse_weight,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_spike,
  output logic signed [lif_pkg::DATA_W-1:0] out_potential
);

  localparam logic signed [lif_pkg::DATA_W-1:0] THRESH =
    lif_pkg::DATA_W'(64'(1) << FRAC_BITS);
  localparam logic signed [35:0] S32_MAX = 36'sh07FFFFFFF;
  localparam logic signed [35:0] S32_MIN = 36'shF80000000;

  function automatic logic signed [lif_pkg::DATA_W-1:0] sat32(
    input logic signed [35:0] v
  );
    logic signed [lif_pkg::DATA_W-1:0] r;
    if (v > S32_MAX)      r = S32_MAX[lif_pkg::DATA_W-1:0];
    else if (v < S32_MIN) r = S32_MIN[lif_pkg::DATA_W-1:0];
    else                  r = v[lif_pkg::DATA_W-1:0];
    return r;
  endfunction

  lif_pkg::cfg_t      cfg;
  lif_pkg::div_stat_t div_st;
  lif_pkg::state_t    state_r, state_nxt;

  logic signed [lif_pkg::DATA_W-1:0] acc_r;
  logic signed [lif_pkg::DATA_W-1:0] pot_r;
  logic [lif_pkg::WIDE_W-1:0]        mag_a_r;
  logic                              neg_a_r, neg_b_r, neg_n_r;
  logic [lif_pkg::WIDE_W-1:0]        q_r;
  logic                              out_valid_r, out_spike_r;
  logic signed [lif_pkg::DATA_W-1:0] out_pot_r;

  logic                              pulse_acc, tick_acc, div_start, out_free;
  logic [lif_pkg::DATA_W-1:0]        abs_acc, abs_pot;
  logic [lif_pkg::WIDE_W-1:0]        prod, mag_b, mag_n;
  logic                              neg_n;
  logic [33:0]                       q_cap;
  logic signed [35:0]                pot_sum;

  lif_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lif_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mag_n),
    .divisor  (cfg.time_constant),
    .quotient (q_r),
    .stat     (div_st)
  );

  assign out_free  = !out_valid_r || out_ready;
  assign pulse_acc = in_valid && in_ready && (in_opcode == lif_pkg::OP_PULSE);
  assign tick_acc  = in_valid && in_ready && (in_opcode == lif_pkg::OP_TICK);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lif_pkg::S_IDLE: if (tick_acc) state_nxt = lif_pkg::S_MUL;
      lif_pkg::S_MUL:  state_nxt = lif_pkg::S_COMB;
      lif_pkg::S_COMB: state_nxt = lif_pkg::S_DIV;
      lif_pkg::S_DIV:  if (div_st.done) state_nxt = lif_pkg::S_FIN;
      lif_pkg::S_FIN:  state_nxt = lif_pkg::S_OUT;
      lif_pkg::S_OUT:  if (out_free) state_nxt = lif_pkg::S_IDLE;
      default:         state_nxt = lif_pkg::S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    unique case (state_r)
      lif_pkg::S_IDLE: in_ready  = 1'b1;
      lif_pkg::S_COMB: div_start = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= lif_pkg::S_IDLE;
    else        state_r <= state_nxt;
  end

  // magnitudes and product of resistance and accumulated input
  assign abs_acc = acc_r[lif_pkg::DATA_W-1] ? lif_pkg::DATA_W'(-acc_r) : acc_r;
  assign abs_pot = pot_r[lif_pkg::DATA_W-1] ? lif_pkg::DATA_W'(-pot_r) : pot_r;
  assign prod    = cfg.resistance * abs_acc;
  assign mag_b   = lif_pkg::WIDE_W'(abs_pot) << FRAC_BITS;

  // signed-magnitude numerator, fed straight into the divider
  always_comb begin
    if (neg_a_r == neg_b_r) begin
      neg_n = neg_a_r;
      mag_n = mag_a_r + mag_b;
    end else if (mag_a_r >= mag_b) begin
      neg_n = neg_a_r;
      mag_n = mag_a_r - mag_b;
    end else begin
      neg_n = neg_b_r;
      mag_n = mag_b - mag_a_r;
    end
  end

  assign q_cap   = (q_r > lif_pkg::DELTA_CAP) ? lif_pkg::DELTA_CAP[33:0] : q_r[33:0];
  assign pot_sum = neg_n_r ? 36'(pot_r) - $signed({2'b00, q_cap})
                           : 36'(pot_r) + $signed({2'b00, q_cap});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      pot_r <= '0;
    end else begin
      if (pulse_acc) acc_r <= sat32(36'(acc_r) + 36'(in_pulse_weight));
      else if (state_r == lif_pkg::S_MUL) acc_r <= '0;
      if (state_r == lif_pkg::S_FIN) pot_r <= sat32(pot_sum);
      else if (state_r == lif_pkg::S_OUT && out_free && pot_r >= THRESH)
        pot_r <= cfg.resting_potential;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == lif_pkg::S_MUL) begin
      mag_a_r <= prod;
      neg_a_r <= acc_r[lif_pkg::DATA_W-1];
      neg_b_r <= (pot_r > 0);
    end
    if (div_start) neg_n_r <= neg_n;
  end

  // output register, loaded once the previous result has gone
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == lif_pkg::S_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == lif_pkg::S_OUT && out_free) begin
      out_spike_r <= (pot_r >= THRESH);
      out_pot_r   <= (pot_r >= THRESH) ? cfg.resting_potential : pot_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_spike     = out_spike_r;
  assign out_potential = out_pot_r;

  `ASSERT_NEXT(a_tick_busy, clk, rst_n, tick_acc, !in_ready)
  `ASSERT_IMPL(a_acc_cleared, clk, rst_n, state_r == lif_pkg::S_FIN, acc_r == '0)
  `ASSERT_IMPL(a_done_in_div, clk, rst_n, div_st.done, state_r == lif_pkg::S_DIV)
  `ASSERT_IMPL(a_busy_in_div, clk, rst_n, div_st.busy, state_r == lif_pkg::S_DIV)
  `ASSERT_NEXT(a_out_load, clk, rst_n, state_r == lif_pkg::S_OUT && out_free, out_valid_r && state_r == lif_pkg::S_IDLE)

endmodule

/* src/lif_regs.sv */
// apb-style configuration registers of the neuron core
// depends on lif_pkg
`timescale 1ns / 1ps

module lif_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lif_pkg::ADDR_W-1:0] paddr,
  input  logic [lif_pkg::DATA_W-1:0] pwdata,
  output logic [lif_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output lif_pkg::cfg_t              cfg
);

  lif_pkg::cfg_t cfg_r;
  logic          wr_en;
  logic [1:0]    idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[3:2];
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.time_constant     <= lif_pkg::TC_RESET;
      cfg_r.resistance        <= lif_pkg::RES_RESET;
      cfg_r.resting_potential <= lif_pkg::VR_RESET;
    end else if (wr_en) begin
      unique case (idx)
        lif_pkg::REG_TIME_CONSTANT:     cfg_r.time_constant     <= pwdata;
        lif_pkg::REG_RESISTANCE:        cfg_r.resistance        <= pwdata;
        lif_pkg::REG_RESTING_POTENTIAL: cfg_r.resting_potential <= $signed(pwdata);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      lif_pkg::REG_TIME_CONSTANT:     prdata = cfg_r.time_constant;
      lif_pkg::REG_RESISTANCE:        prdata = cfg_r.resistance;
      lif_pkg::REG_RESTING_POTENTIAL: prdata = cfg_r.resting_potential;
      default:                        prdata = '0;
    endcase
  end

endmodule

/* src/lif_div.sv */
// restoring divider, one quotient bit per cycle on a shared subtractor
// depends on lif_pkg
`timescale 1ns / 1ps

module lif_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [lif_pkg::WIDE_W-1:0] dividend,
  input  logic [lif_pkg::DATA_W-1:0] divisor,
  output logic [lif_pkg::WIDE_W-1:0] quotient,
  output lif_pkg::div_stat_t         stat
);

  logic [lif_pkg::WIDE_W-1:0] quo_r, quo_nxt;
  logic [lif_pkg::DATA_W-1:0] rem_r, rem_nxt;
  logic [lif_pkg::DATA_W-1:0] dsr_r;
  logic [lif_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [lif_pkg::DATA_W+1:0] trial;

  // shift in the next dividend bit and try the subtraction
  assign trial = {1'b0, rem_r, quo_r[lif_pkg::WIDE_W-1]} - {2'b00, dsr_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[lif_pkg::DATA_W+1]) begin
        rem_nxt = trial[lif_pkg::DATA_W-1:0];
        quo_nxt = {quo_r[lif_pkg::WIDE_W-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[lif_pkg::DATA_W-2:0], quo_r[lif_pkg::WIDE_W-1]};
        quo_nxt = {quo_r[lif_pkg::WIDE_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == lif_pkg::CNT_W'(lif_pkg::DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    // zero time constant behaves as the smallest nonzero code
    if (start) dsr_r <= (divisor == '0) ? lif_pkg::DATA_W'(1) : divisor;
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule
